### rtl/s256h_pkg.sv
// s256h_pkg: shared types, constants and round functions of the sha-256 stream hasher
package s256h_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned NUM_H    = 8;
	localparam int unsigned NUM_W    = 16;
	localparam int unsigned ROUND_W  = 6;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned COUNT_W  = 64;

	localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
	localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
	localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0][BYTE_W-1:0] word_bytes_t;

	localparam word_t IV [NUM_H] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PAD_LEN,
		ST_ROUND,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		POST_IDLE,
		POST_PAD,
		POST_PAD_LEN,
		POST_OUT
	} post_t;

	typedef struct packed {
		logic               write_byte;
		logic               start;
		logic               pad_first;
		logic               pad_len;
		logic               round;
		logic [ROUND_W-1:0] round_idx;
		logic               update;
		logic               finish;
		logic [IDX_W-1:0]   word_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic last_slot;
		logic pad_long;
	} dp_stat_t;

	function automatic word_t ror(input word_t x, input int unsigned n);
		ror = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_s0(input word_t x);
		big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t small_s0(input word_t x);
		small_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		small_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage

### rtl/s256h_stream_if.sv
// s256h_stream_if: message byte and digest word channel interfaces
interface s256h_msg_if import s256h_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

interface s256h_digest_if import s256h_pkg::*; ();
	logic             valid;
	logic             ready;
	word_t            digest_word;
	logic [IDX_W-1:0] word_index;
	logic             last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

### rtl/s256h_ctrl.sv
// s256h_ctrl: sequencing state machine for loading, padding, rounds and digest output
module s256h_ctrl import s256h_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_has_byte,
	input  logic             in_eom,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] word_idx,
	output dp_cmd_t          cmd,
	input  dp_stat_t         stat
);

	state_t             state_q, state_nxt;
	post_t              after_q, after_nxt;
	logic [ROUND_W-1:0] round_q, round_nxt;
	logic [IDX_W-1:0]   word_q, word_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= POST_IDLE;
			round_q <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_nxt;
			after_q <= after_nxt;
			round_q <= round_nxt;
			word_q  <= word_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		after_nxt = after_q;
		round_nxt = round_q;
		word_nxt  = word_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.round_idx = round_q;
		cmd.word_sel  = word_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_has_byte) begin
						cmd.write_byte = 1'b1;
					end
					if (in_has_byte && stat.last_slot) begin
						// block full: compress, then pad if the message ends here
						cmd.start = 1'b1;
						after_nxt = in_eom ? POST_PAD : POST_IDLE;
						state_nxt = ST_ROUND;
					end else if (in_eom) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.pad_first = 1'b1;
				cmd.start     = 1'b1;
				after_nxt     = stat.pad_long ? POST_PAD_LEN : POST_OUT;
				state_nxt     = ST_ROUND;
			end
			ST_PAD_LEN: begin
				cmd.pad_len = 1'b1;
				cmd.start   = 1'b1;
				after_nxt   = POST_OUT;
				state_nxt   = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				round_nxt = round_q + 1'b1;
				if (round_q == LAST_ROUND) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				unique case (after_q)
					POST_IDLE:    state_nxt = ST_IDLE;
					POST_PAD:     state_nxt = ST_PAD;
					POST_PAD_LEN: state_nxt = ST_PAD_LEN;
					POST_OUT:     state_nxt = ST_OUT;
				endcase
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					word_nxt = word_q + 1'b1;
					if (word_q == LAST_IDX) begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign word_idx = word_q;

`ifndef SYNTHESIS
	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && $past(state_q) != ST_ROUND) |-> round_q == '0)
		else $error("compression entered with round counter not at zero");
	a_last_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && word_q == LAST_IDX) |=> (state_q == ST_IDLE && word_q == '0))
		else $error("digest not closed after final word transaction");
	a_len_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && after_q == POST_PAD_LEN) |=> state_q == ST_PAD_LEN)
		else $error("length block skipped after long padding");
`endif

endmodule

### rtl/s256h_datapath.sv
// s256h_datapath: message window, round registers, chaining words and byte count
module s256h_datapath import s256h_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [BYTE_W-1:0] data_byte,
	output dp_stat_t          stat,
	output word_t             digest_word
);

	word_t                h_q [NUM_H];
	logic [COUNT_W-1:0]   cnt_q;
	word_bytes_t          w_q [NUM_W];
	word_t                v_q [NUM_H];

	word_bytes_t          w_pad [NUM_W];
	logic [COUNT_W-1:0]   len_bits;
	logic [5:0]           pos;
	word_t                w_new, t1, a_new, e_new, ch, maj;

	assign pos      = cnt_q[5:0];
	assign len_bits = {cnt_q[COUNT_W-4:0], 3'b000};

	assign stat.last_slot = (pos == 6'd63);
	assign stat.pad_long  = (pos[5:3] == 3'b111);

	// padding image of the block window
	always_comb begin
		logic [5:0] bp;
		for (int j = 0; j < NUM_W; j++) begin
			for (int k = 0; k < 4; k++) begin
				bp = 6'(4 * j + k);
				if (cmd.pad_len || bp > pos) begin
					w_pad[j][3-k] = '0;
				end else if (bp == pos) begin
					w_pad[j][3-k] = PAD_MARK;
				end else begin
					w_pad[j][3-k] = w_q[j][3-k];
				end
			end
		end
		if (cmd.pad_len || !stat.pad_long) begin
			w_pad[NUM_W-2] = len_bits[63:32];
			w_pad[NUM_W-1] = len_bits[31:0];
		end
	end

	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_s1(v_q[4]) + ch + K_TABLE[cmd.round_idx] + w_q[0];
		a_new = t1 + big_s0(v_q[0]) + maj;
		e_new = v_q[3] + t1;
		w_new = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= IV;
			cnt_q <= '0;
		end else begin
			if (cmd.finish) begin
				h_q   <= IV;
				cnt_q <= '0;
			end else begin
				if (cmd.update) begin
					for (int i = 0; i < NUM_H; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
				if (cmd.write_byte) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int j = 0; j < NUM_W - 1; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[NUM_W-1] <= w_new;
		end else if (cmd.pad_first || cmd.pad_len) begin
			w_q <= w_pad;
		end else if (cmd.write_byte) begin
			w_q[pos[5:2]][2'd3 - pos[1:0]] <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			v_q <= h_q;
		end else if (cmd.round) begin
			v_q[0] <= a_new;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= e_new;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	assign digest_word = h_q[cmd.word_sel];

`ifndef SYNTHESIS
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (cnt_q == '0 && h_q[0] == IV[0] && h_q[NUM_H-1] == IV[NUM_H-1]))
		else $error("chaining words or byte count not restored after digest");
`endif

endmodule

### rtl/sha256_stream_hasher_core.sv
// sha256_stream_hasher_core: top level of the sha-256 byte stream hasher
//
//  channel  dir  payload                                   transaction
//  msg      in   data_byte[7:0], has_byte, end_of_message  valid && ready
//  digest   out  digest_word[31:0], word_index[2:0],       valid && ready
//                last_word
//
// a byte item is accepted while the core is idle; the byte that fills a 64-byte block
// starts a compression (64 rounds of the single round unit plus the chaining update)
// end of message: a padded block is compressed, and a second (length) block too when the
// last block holds 56 or more bytes, then eight digest transactions
// reset loads the initial hash values and clears the byte count
// msg is held off during compression, padding and output; a stalled digest word holds
module sha256_stream_hasher_core import s256h_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	s256h_msg_if.sink        msg,
	s256h_digest_if.source   digest
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] word_idx;

	s256h_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (msg.valid),
		.in_has_byte (msg.has_byte),
		.in_eom      (msg.end_of_message),
		.in_ready    (msg.ready),
		.out_valid   (digest.valid),
		.out_ready   (digest.ready),
		.word_idx    (word_idx),
		.cmd         (cmd),
		.stat        (stat)
	);

	s256h_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.stat        (stat),
		.digest_word (digest.digest_word)
	);

	assign digest.word_index = word_idx;
	assign digest.last_word  = (word_idx == LAST_IDX);

endmodule
